>>> src/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types and constants of the addressed frame receiver: register
// indexes, reset values, result status codes and the controller interface.
// ----------------------------------------------------------------------------
package afr_pkg;

	localparam int MAX_PAYLOAD_DEF = 64;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_ID     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOWNLOAD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODULE_ADDR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND = 3'd5;

	localparam logic [7:0] START_BYTE_RST  = 8'h7f;
	localparam logic [7:0] NODE_ID_RST     = 8'h00;
	localparam logic [7:0] DOWNLOAD_RST    = 8'h00;
	localparam logic [7:0] MODULE_ADDR_RST = 8'h00;
	localparam logic [7:0] TAIL_FIRST_RST  = 8'h0d;
	localparam logic [7:0] TAIL_SECOND_RST = 8'h0a;

	localparam int HDR_LEN = 4;

	localparam logic [1:0] ST_PAYLOAD  = 2'd0;
	localparam logic [1:0] ST_EMPTY_OK = 2'd1;
	localparam logic [1:0] ST_BAD_TAIL = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	typedef struct packed {
		logic take;
		logic load_stat;
		logic load_pay;
	} ctrl_cmd_t;

	typedef struct packed {
		logic res_stat;
		logic res_pay;
		logic out_free;
		logic last_pay;
	} dp_stat_t;

endpackage

>>> src/afr_ctrl.sv
// ----------------------------------------------------------------------------
// afr_ctrl
// Word sequencer: takes received words, then issues status or payload
// result words one at a time into the output register.
// ----------------------------------------------------------------------------
module afr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  afr_pkg::dp_stat_t  dp_stat,
	output afr_pkg::ctrl_cmd_t ctrl_cmd
);

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_STAT = 4'b0010,
		C_READ = 4'b0100,
		C_LOAD = 4'b1000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != C_IDLE);

	always_comb begin
		state_d            = state_q;
		ctrl_cmd.take      = 1'b0;
		ctrl_cmd.load_stat = 1'b0;
		ctrl_cmd.load_pay  = 1'b0;
		unique case (state_q)
			C_IDLE: begin
				if (in_valid) begin
					ctrl_cmd.take = 1'b1;
					if (dp_stat.res_stat) begin
						state_d = C_STAT;
					end else if (dp_stat.res_pay) begin
						state_d = C_READ;
					end
				end
			end
			C_STAT: begin
				if (dp_stat.out_free) begin
					ctrl_cmd.load_stat = 1'b1;
					state_d            = C_IDLE;
				end
			end
			C_READ: begin
				state_d = C_LOAD;
			end
			C_LOAD: begin
				if (dp_stat.out_free) begin
					ctrl_cmd.load_pay = 1'b1;
					state_d           = dp_stat.last_pay ? C_IDLE : C_READ;
				end
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

endmodule

>>> src/afr_dp.sv
// ----------------------------------------------------------------------------
// afr_dp
// Datapath: configuration registers, header hunt, frame parse registers,
// payload memory and the output register.
// ----------------------------------------------------------------------------
module afr_dp #(
	parameter int MAX_PAYLOAD = afr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [afr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic [7:0]                     rx_byte,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [7:0]                     payload_byte,
	output logic [5:0]                     byte_index,
	output logic [1:0]                     status,
	output logic                           last,
	input  afr_pkg::ctrl_cmd_t             ctrl_cmd,
	output afr_pkg::dp_stat_t              dp_stat
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int LW = $clog2(MAX_PAYLOAD + 1);

	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_LENGTH  = 5'b00010,
		PH_PAYLOAD = 5'b00100,
		PH_TAIL1   = 5'b01000,
		PH_TAIL2   = 5'b10000
	} phase_t;

	logic [7:0] start_q, node_q, dl_q, mod_q, tail1_q, tail2_q;
	phase_t     phase_q;
	logic [1:0] hunt_cnt_q;
	logic [LW-1:0] frame_len_q, taken_q, rd_idx_q;
	logic [7:0] tail_seen_q;
	logic [1:0] stat_code_q;
	logic [7:0] mem_q [MAX_PAYLOAD];
	logic [7:0] rd_data_q;
	logic       out_valid_q;
	logic [7:0] pay_q;
	logic [5:0] idx_q;
	logic [1:0] status_q;
	logic       last_q;

	logic [3:0][7:0] hdr;
	logic [2:0]      hunt_nxt;
	logic            too_long, tail_good;
	logic [LW-1:0]   taken_inc, rd_inc;

	function automatic logic [2:0] hunt_next(input logic [3:0][7:0] h,
		input logic [1:0] k, input logic [7:0] b);
		logic [2:0] res;
		logic       ok;
		res = 3'd0;
		if (b == h[k]) begin
			res = {1'b0, k} + 3'd1;
		end else begin
			for (int len = 1; len < afr_pkg::HDR_LEN; len++) begin
				if (len <= int'(k)) begin
					ok = (b == h[2'(len - 1)]);
					for (int i = 0; i < afr_pkg::HDR_LEN - 2; i++) begin
						if (i < len - 1) begin
							if (h[2'(int'(k) + 1 - len + i)] != h[2'(i)]) begin
								ok = 1'b0;
							end
						end
					end
					if (ok) begin
						res = 3'(len);
					end
				end
			end
		end
		return res;
	endfunction

	assign hdr       = {mod_q, dl_q, node_q, start_q};
	assign hunt_nxt  = hunt_next(hdr, hunt_cnt_q, rx_byte);
	assign too_long  = (rx_byte > 8'(MAX_PAYLOAD));
	assign tail_good = (tail_seen_q == tail1_q) && (rx_byte == tail2_q);
	assign taken_inc = LW'(taken_q + 1'b1);
	assign rd_inc    = LW'(rd_idx_q + 1'b1);

	always_comb begin
		dp_stat.res_stat = 1'b0;
		dp_stat.res_pay  = 1'b0;
		dp_stat.out_free = !out_valid_q || !out_stall;
		dp_stat.last_pay = (rd_inc == frame_len_q);
		unique case (phase_q)
			PH_LENGTH: dp_stat.res_stat = too_long;
			PH_TAIL2: begin
				dp_stat.res_stat = !tail_good || (frame_len_q == '0);
				dp_stat.res_pay  = tail_good && (frame_len_q != '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= afr_pkg::START_BYTE_RST;
			node_q  <= afr_pkg::NODE_ID_RST;
			dl_q    <= afr_pkg::DOWNLOAD_RST;
			mod_q   <= afr_pkg::MODULE_ADDR_RST;
			tail1_q <= afr_pkg::TAIL_FIRST_RST;
			tail2_q <= afr_pkg::TAIL_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				afr_pkg::REG_START_BYTE:  start_q <= cfg_data;
				afr_pkg::REG_NODE_ID:     node_q  <= cfg_data;
				afr_pkg::REG_DOWNLOAD:    dl_q    <= cfg_data;
				afr_pkg::REG_MODULE_ADDR: mod_q   <= cfg_data;
				afr_pkg::REG_TAIL_FIRST:  tail1_q <= cfg_data;
				afr_pkg::REG_TAIL_SECOND: tail2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			hunt_cnt_q <= '0;
			taken_q    <= '0;
		end else if (ctrl_cmd.take) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (hunt_nxt == 3'(afr_pkg::HDR_LEN)) begin
						phase_q    <= PH_LENGTH;
						hunt_cnt_q <= '0;
					end else begin
						hunt_cnt_q <= hunt_nxt[1:0];
					end
				end
				PH_LENGTH: begin
					taken_q <= '0;
					if (too_long) begin
						phase_q <= PH_HUNT;
					end else if (rx_byte == 8'd0) begin
						phase_q <= PH_TAIL1;
					end else begin
						phase_q <= PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					taken_q <= taken_inc;
					if (taken_inc == frame_len_q) begin
						phase_q <= PH_TAIL1;
					end
				end
				PH_TAIL1: phase_q <= PH_TAIL2;
				PH_TAIL2: begin
					phase_q    <= PH_HUNT;
					hunt_cnt_q <= '0;
					taken_q    <= '0;
				end
				default: phase_q <= PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_cmd.take) begin
			if (phase_q == PH_LENGTH && !too_long) begin
				frame_len_q <= LW'(rx_byte);
			end
			if (phase_q == PH_TAIL1) begin
				tail_seen_q <= rx_byte;
			end
			if (phase_q == PH_LENGTH) begin
				stat_code_q <= afr_pkg::ST_TOO_LONG;
			end else if (!tail_good) begin
				stat_code_q <= afr_pkg::ST_BAD_TAIL;
			end else begin
				stat_code_q <= afr_pkg::ST_EMPTY_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_cmd.take && phase_q == PH_PAYLOAD) begin
			mem_q[taken_q[AW-1:0]] <= rx_byte;
		end
		rd_data_q <= mem_q[rd_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctrl_cmd.take) begin
			rd_idx_q <= '0;
		end else if (ctrl_cmd.load_pay) begin
			rd_idx_q <= rd_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl_cmd.load_stat || ctrl_cmd.load_pay) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_cmd.load_stat) begin
			pay_q    <= 8'd0;
			idx_q    <= 6'd0;
			status_q <= stat_code_q;
			last_q   <= 1'b1;
		end else if (ctrl_cmd.load_pay) begin
			pay_q    <= rd_data_q;
			idx_q    <= 6'(rd_idx_q);
			status_q <= afr_pkg::ST_PAYLOAD;
			last_q   <= dp_stat.last_pay;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = pay_q;
	assign byte_index   = idx_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

>>> src/addressed_frame_receiver.sv
// ----------------------------------------------------------------------------
// addressed_frame_receiver
// Hunts received words for the four-byte header, stores the payload and
// checks the two-byte trailer; delivers payload or status result words.
// ----------------------------------------------------------------------------
// A received word is taken whenever the receiver is idle. A word that closes
// a frame holds the input while each payload word passes through a payload
// memory read and then an output register load, or while a status word is
// loaded, and for as long as the output stalls. A finished result waits
// in the output register while the next received word is taken. No clearing
// pass follows reset.
module addressed_frame_receiver #(
	parameter int MAX_PAYLOAD = afr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [afr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    payload_byte,
	output logic [5:0]                    byte_index,
	output logic [1:0]                    status,
	output logic                          last
);

	afr_pkg::ctrl_cmd_t ctrl_cmd;
	afr_pkg::dp_stat_t  dp_stat;

	afr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.dp_stat  (dp_stat),
		.ctrl_cmd (ctrl_cmd)
	);

	afr_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rx_byte      (rx_byte),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.status       (status),
		.last         (last),
		.ctrl_cmd     (ctrl_cmd),
		.dp_stat      (dp_stat)
	);

	a_status_word_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != afr_pkg::ST_PAYLOAD) |->
		(last && payload_byte == 8'd0 && byte_index == 6'd0))
		else $error("status word with payload fields set");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_cmd.load_stat || ctrl_cmd.load_pay) |-> (!out_valid || !out_stall))
		else $error("output register loaded while holding a stalled word");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.take |-> !(ctrl_cmd.load_stat || ctrl_cmd.load_pay))
		else $error("input taken during result load");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the addressed frame receiver. Received words come
// from a queue that an initial block fills with well-formed frames, broken
// headers, bad trailers, over-length frames and line noise. A deframing
// predictor runs on every accepted word and queues the result words it
// expects; the monitor checks each delivered word field by field. Phases
// cover several register settings and idle/stall mixes, plus one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PAYLOAD   = afr_pkg::MAX_PAYLOAD_DEF;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_WORDS   = 16;
	localparam int HOLD_FRAMES   = 3;

	localparam logic [afr_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [afr_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int PH_HUNT    = 0;
	localparam int PH_LENGTH  = 4;
	localparam int PH_PAYLOAD = 5;
	localparam int PH_TAIL1   = 6;
	localparam int PH_TAIL2   = 7;

	localparam int TAIL_GOOD       = 0;
	localparam int TAIL_BAD_FIRST  = 1;
	localparam int TAIL_BAD_SECOND = 2;
	localparam int TAIL_BAD_BOTH   = 3;

	typedef struct {
		logic [7:0] data;
		logic [5:0] index;
		logic [1:0] code;
		logic       is_last;
	} frame_result_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [afr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                    cfg_data  = '0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	logic [7:0]                    rx_byte   = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [7:0]                    payload_byte;
	logic [5:0]                    byte_index;
	logic [1:0]                    status;
	logic                          last;

	logic [7:0]    pending_rx[$];
	frame_result_t expected_results[$];
	frame_result_t want;

	logic [7:0] cfg_shadow [0:5];
	int         parse_phase;
	logic [7:0] frame_len;
	logic [6:0] bytes_taken;
	logic [7:0] tail1_seen;
	logic [7:0] payload_copy [0:63];

	int  words_queued    = 0;
	int  words_sent      = 0;
	int  results_checked = 0;
	int  error_count     = 0;
	int  frames_data     = 0;
	int  frames_empty    = 0;
	int  bad_tails       = 0;
	int  too_long        = 0;
	int  send_idle_pct   = 0;
	int  recv_stall_pct  = 0;
	int  cycle_count     = 0;
	bit  hold_trigger    = 1'b0;
	logic long_hold      = 1'b0;

	addressed_frame_receiver #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.status       (status),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Deframing predictor
	// ------------------------------------------------------------------
	function automatic int next_match(int k, logic [7:0] b);
		int len;
		int i;
		bit ok;
		if (b == cfg_shadow[k])
			return k + 1;
		for (len = k; len >= 1; len--) begin
			ok = (b == cfg_shadow[len-1]);
			for (i = 0; ok && i + 1 < len; i++)
				if (cfg_shadow[k+1-len+i] != cfg_shadow[i])
					ok = 1'b0;
			if (ok)
				return len;
		end
		return 0;
	endfunction

	function automatic void push_result(logic [7:0] data, logic [5:0] index, logic [1:0] code,
			logic is_last);
		frame_result_t r;
		r.data    = data;
		r.index   = index;
		r.code    = code;
		r.is_last = is_last;
		expected_results.push_back(r);
	endfunction

	function automatic void deframe_rx_byte(logic [7:0] b);
		int i;
		case (parse_phase)
			PH_LENGTH: begin
				if (b > MAX_PAYLOAD) begin
					push_result(8'h00, 6'd0, afr_pkg::ST_TOO_LONG, 1'b1);
					too_long++;
					parse_phase = PH_HUNT;
					bytes_taken = '0;
				end else begin
					frame_len   = b;
					bytes_taken = '0;
					parse_phase = (b == 0) ? PH_TAIL1 : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				payload_copy[bytes_taken[5:0]] = b;
				bytes_taken = bytes_taken + 7'd1;
				if ({1'b0, bytes_taken} >= frame_len)
					parse_phase = PH_TAIL1;
			end
			PH_TAIL1: begin
				tail1_seen  = b;
				parse_phase = PH_TAIL2;
			end
			PH_TAIL2: begin
				if (tail1_seen == cfg_shadow[afr_pkg::REG_TAIL_FIRST] &&
						b == cfg_shadow[afr_pkg::REG_TAIL_SECOND]) begin
					if (frame_len == 0) begin
						push_result(8'h00, 6'd0, afr_pkg::ST_EMPTY_OK, 1'b1);
						frames_empty++;
					end else begin
						for (i = 0; i < frame_len; i++)
							push_result(payload_copy[i], 6'(i), afr_pkg::ST_PAYLOAD,
								(i + 1 == frame_len));
						frames_data++;
					end
				end else begin
					push_result(8'h00, 6'd0, afr_pkg::ST_BAD_TAIL, 1'b1);
					bad_tails++;
				end
				parse_phase = PH_HUNT;
				bytes_taken = '0;
			end
			0, 1, 2, 3: parse_phase = next_match(parse_phase, b);
			default: parse_phase = next_match(0, b);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver and monitor
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				deframe_rx_byte(rx_byte);
				words_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_rx.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte  <= pending_rx.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result word: payload_byte %0h byte_index %0d status %0d last %0b",
						payload_byte, byte_index, status, last);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (payload_byte !== want.data) begin
						$error("payload_byte: expected %0h, got %0h", want.data, payload_byte);
						error_count++;
					end
					if (byte_index !== want.index) begin
						$error("byte_index: expected %0d, got %0d", want.index, byte_index);
						error_count++;
					end
					if (status !== want.code) begin
						$error("status: expected %0d, got %0d", want.code, status);
						error_count++;
					end
					if (last !== want.is_last) begin
						$error("last: expected %0b, got %0b", want.is_last, last);
						error_count++;
					end
					results_checked++;
				end
			end
			out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// hold off the receiver while the sender keeps offering words
	initial begin
		wait (hold_trigger);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("addressed_frame_receiver verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic void queue_byte(logic [7:0] b);
		pending_rx.push_back(b);
		words_queued++;
	endfunction

	function automatic logic [7:0] flip(logic [7:0] b);
		return b ^ 8'($urandom_range(1, 255));
	endfunction

	function automatic void queue_header();
		int i;
		for (i = 0; i < afr_pkg::HDR_LEN; i++)
			queue_byte(cfg_shadow[i]);
	endfunction

	function automatic void queue_tail(int mode);
		queue_byte((mode == TAIL_BAD_FIRST || mode == TAIL_BAD_BOTH) ?
			flip(cfg_shadow[afr_pkg::REG_TAIL_FIRST]) : cfg_shadow[afr_pkg::REG_TAIL_FIRST]);
		queue_byte((mode == TAIL_BAD_SECOND || mode == TAIL_BAD_BOTH) ?
			flip(cfg_shadow[afr_pkg::REG_TAIL_SECOND]) : cfg_shadow[afr_pkg::REG_TAIL_SECOND]);
	endfunction

	function automatic void queue_frame(int len, int mode);
		int i;
		queue_header();
		queue_byte(8'(len));
		for (i = 0; i < len; i++)
			queue_byte(8'($urandom_range(255)));
		queue_tail(mode);
	endfunction

	function automatic void queue_too_long(int len);
		queue_header();
		queue_byte(8'(len));
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return MAX_PAYLOAD;
		if (r < 14)
			return $urandom_range(9, MAX_PAYLOAD);
		return $urandom_range(0, 8);
	endfunction

	function automatic void queue_random_traffic(int n_words);
		int counted;
		int mark;
		int r;
		int k;
		int i;
		counted = 0;
		while (counted < n_words) begin
			mark = words_queued;
			r = $urandom_range(99);
			if (r < 60) begin
				queue_frame(pick_length(), TAIL_GOOD);
			end else if (r < 70) begin
				queue_frame($urandom_range(0, 4), $urandom_range(TAIL_BAD_FIRST, TAIL_BAD_BOTH));
			end else if (r < 78) begin
				queue_too_long($urandom_range(MAX_PAYLOAD + 1, 255));
			end else if (r < 88) begin
				k = $urandom_range(1, afr_pkg::HDR_LEN - 1);
				for (i = 0; i < k; i++)
					queue_byte(cfg_shadow[i]);
				queue_byte(flip(cfg_shadow[k]));
			end else begin
				for (i = $urandom_range(1, 4); i > 0; i--)
					queue_byte($urandom_range(1) ?
						cfg_shadow[$urandom_range(0, afr_pkg::HDR_LEN - 1)] :
						8'($urandom_range(255)));
			end
			counted += words_queued - mark;
		end
	endfunction

	task automatic drain();
		while (words_sent != words_queued || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [afr_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= afr_pkg::REG_TAIL_SECOND)
			cfg_shadow[idx] = value;
	endtask

	task automatic set_registers(logic [7:0] sb, logic [7:0] nid, logic [7:0] dl, logic [7:0] ma,
			logic [7:0] t1, logic [7:0] t2);
		write_reg(afr_pkg::REG_START_BYTE, sb);
		write_reg(afr_pkg::REG_NODE_ID, nid);
		write_reg(afr_pkg::REG_DOWNLOAD, dl);
		write_reg(afr_pkg::REG_MODULE_ADDR, ma);
		write_reg(afr_pkg::REG_TAIL_FIRST, t1);
		write_reg(afr_pkg::REG_TAIL_SECOND, t2);
		write_reg(REG_SPARE_LO, 8'($urandom_range(255)));
		write_reg(REG_SPARE_HI, 8'($urandom_range(255)));
		@(negedge clk);
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	initial begin
		logic [7:0] a;
		logic [7:0] b;
		int i;

		cfg_shadow[afr_pkg::REG_START_BYTE]  = afr_pkg::START_BYTE_RST;
		cfg_shadow[afr_pkg::REG_NODE_ID]     = afr_pkg::NODE_ID_RST;
		cfg_shadow[afr_pkg::REG_DOWNLOAD]    = afr_pkg::DOWNLOAD_RST;
		cfg_shadow[afr_pkg::REG_MODULE_ADDR] = afr_pkg::MODULE_ADDR_RST;
		cfg_shadow[afr_pkg::REG_TAIL_FIRST]  = afr_pkg::TAIL_FIRST_RST;
		cfg_shadow[afr_pkg::REG_TAIL_SECOND] = afr_pkg::TAIL_SECOND_RST;
		for (i = 0; i < 64; i++)
			payload_copy[i] = '0;
		parse_phase = PH_HUNT;
		frame_len   = '0;
		bytes_taken = '0;
		tail1_seen  = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: restart on a repeated start byte, empty frame, one-word frame,
		// over-length frame, bad trailer
		queue_byte(cfg_shadow[afr_pkg::REG_START_BYTE]);
		queue_frame(0, TAIL_GOOD);
		queue_header();
		queue_byte(8'd1);
		queue_byte(8'hff);
		queue_tail(TAIL_GOOD);
		queue_too_long(255);
		queue_frame(0, TAIL_BAD_SECOND);
		drain();

		set_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		set_idling(0, 0);
		queue_frame(MAX_PAYLOAD, TAIL_GOOD);
		queue_too_long(MAX_PAYLOAD + 1);
		queue_random_traffic(PHASE_WORDS);
		drain();

		set_registers(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
		set_idling(85, 0);
		queue_random_traffic(PHASE_WORDS);
		// leave a frame open across the next register write
		queue_header();
		queue_byte(8'd1);
		queue_byte(8'($urandom_range(255)));
		drain();

		set_registers(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		set_idling(0, 85);
		queue_tail(TAIL_GOOD);
		queue_random_traffic(PHASE_WORDS);
		drain();

		// self-overlapping header exercises the hunt restart
		a = 8'($urandom_range(255));
		b = a ^ 8'h5a;
		case ($urandom_range(2))
			0: set_registers(a, a, a, b, 8'($urandom_range(255)), 8'($urandom_range(255)));
			1: set_registers(a, b, a, b, 8'($urandom_range(255)), 8'($urandom_range(255)));
			default: set_registers(a, a, b, a, 8'($urandom_range(255)), 8'($urandom_range(255)));
		endcase
		set_idling(34, 34);
		queue_random_traffic(PHASE_WORDS);
		drain();

		set_registers(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		set_idling(0, 0);
		hold_trigger = 1'b1;
		for (i = 0; i < HOLD_FRAMES; i++)
			queue_frame($urandom_range(8, 16), TAIL_GOOD);
		drain();

		$display("Sent %0d received words and checked %0d result words over six register settings",
			words_sent, results_checked);
		$display("Frames: %0d with payload, %0d empty, %0d bad trailer, %0d over length",
			frames_data, frames_empty, bad_tails, too_long);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("addressed_frame_receiver verification clean");
		end else begin
			$display("addressed_frame_receiver verification failed");
		end
		$finish;
	end

endmodule
